### design/fvm_pkg.sv
package fvm_pkg;

  // default sizes
  localparam int MAX_TAPS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // coefficient format, fixed at q1.15
  localparam int COEF_BITS = 16;
  localparam int COEF_FRAC = 15;

  // register widths
  localparam int TAP_COUNT_BITS  = 7;
  localparam int COEF_INDEX_BITS = 6;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_INDEX_BITS  = 2;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_INDEX = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_VALUE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;    // item taken this cycle
    logic issue;     // read one tap pair
    logic load_out;  // round, saturate, load output register
  } fvm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic produce;    // item being offered completes a window
    logic last_tap;   // this issue reads the last tap
    logic pipe_busy;  // products still in flight
    logic out_free;   // output register can take a result
  } fvm_status_t;

endpackage

### design/fvm_in_if.sv
interface fvm_in_if
  import fvm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          block_start;

  modport source (output valid, output sample, output block_start, input ready);
  modport sink   (input valid, input sample, input block_start, output ready);
endinterface

### design/fvm_out_if.sv
interface fvm_out_if
  import fvm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

### design/fvm_ram.sv
module fvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fvm_ctrl.sv
module fvm_ctrl
  import fvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  fvm_status_t status,
  output fvm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.issue    = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.produce) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (status.last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy && status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/fvm_dpath.sv
module fvm_dpath
  import fvm_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fvm_cmd_t                      cmd,
  output fvm_status_t                   status,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          block_start,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] filtered,
  output logic                          saturated
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int PW    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W = PW + AW + 1;
  localparam int SHW   = ACC_W - COEF_FRAC;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (COEF_FRAC - 1));

  // configuration
  logic [TAP_COUNT_BITS-1:0]  tap_count;
  logic [COEF_INDEX_BITS-1:0] coef_index;
  logic [MAX_TAPS-1:0]        coef_valid;
  logic                       coef_we;
  logic [CW-1:0]              taps_eff;

  // sample window
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_base;
  logic [CW-1:0] fill_next;
  logic [AW-1:0] rd_ptr;
  logic [AW+1:0] start_sum;
  logic [AW-1:0] start_ptr;
  logic [AW-1:0] tap_k;

  // mac pipeline
  logic [COEF_BITS-1:0]          coef_q;
  logic signed [SAMPLE_BITS-1:0] hist_q;
  logic                          coef_ok;
  logic signed [COEF_BITS-1:0]   coef_eff;
  logic                          rd_vld;
  logic                          prod_vld;
  logic signed [PW-1:0]          prod;
  logic signed [ACC_W-1:0]       acc;

  // rounding and clipping
  logic signed [ACC_W-1:0]       rnd;
  logic [SHW-1:0]                shv;
  logic                          sat_hi;
  logic                          sat_lo;
  logic signed [SAMPLE_BITS-1:0] y;

  assign taps_eff = (32'(tap_count) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(tap_count);
  assign coef_we  = cfg_we && (cfg_index == REG_COEF_VALUE) && (32'(coef_index) < MAX_TAPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count  <= '0;
      coef_index <= '0;
      coef_valid <= '0;
    end else begin
      if (coef_we) begin
        coef_valid[AW'(coef_index)] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TAP_COUNT:  tap_count  <= cfg_data[TAP_COUNT_BITS-1:0];
          REG_COEF_INDEX: coef_index <= cfg_data[COEF_INDEX_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  fvm_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (AW'(coef_index)),
    .wdata (cfg_data[COEF_BITS-1:0]),
    .raddr (tap_k),
    .rdata (coef_q)
  );

  fvm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wr_ptr),
    .wdata (sample),
    .raddr (rd_ptr),
    .rdata (hist_q)
  );

  // window bookkeeping for the item on offer
  assign fill_base = block_start ? '0 : fill;
  assign fill_next = (32'(fill_base) < MAX_TAPS) ? CW'(fill_base + CW'(1)) : fill_base;

  // oldest tap sits taps_eff-1 entries behind the slot being written
  assign start_sum = (AW+2)'(wr_ptr) + (AW+2)'(MAX_TAPS) + (AW+2)'(1) - (AW+2)'(taps_eff);
  assign start_ptr = (32'(start_sum) >= MAX_TAPS) ? AW'(start_sum - (AW+2)'(MAX_TAPS))
                                                  : AW'(start_sum);

  assign status.produce   = (taps_eff != '0) && (fill_next >= taps_eff);
  assign status.last_tap  = (CW'(tap_k) + CW'(1)) == taps_eff;
  assign status.pipe_busy = rd_vld || prod_vld;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      fill     <= '0;
      rd_ptr   <= '0;
      tap_k    <= '0;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= cmd.issue;
      prod_vld <= rd_vld;
      if (cmd.accept) begin
        wr_ptr <= (32'(wr_ptr) == MAX_TAPS - 1) ? '0 : AW'(wr_ptr + AW'(1));
        fill   <= fill_next;
        rd_ptr <= start_ptr;
        tap_k  <= '0;
      end else if (cmd.issue) begin
        rd_ptr <= (32'(rd_ptr) == MAX_TAPS - 1) ? '0 : AW'(rd_ptr + AW'(1));
        tap_k  <= AW'(tap_k + AW'(1));
      end
    end
  end

  // unwritten coefficient slots read as zero
  assign coef_eff = coef_ok ? $signed(coef_q) : '0;

  always_ff @(posedge clk) begin
    coef_ok <= coef_valid[tap_k];
    prod    <= coef_eff * hist_q;
    if (cmd.accept) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up at the binary point, then clip to the sample range
  assign rnd    = acc + RND_HALF;
  assign shv    = rnd[ACC_W-1:COEF_FRAC];
  assign sat_hi = !shv[SHW-1] && (shv[SHW-2:SAMPLE_BITS-1] != '0);
  assign sat_lo = shv[SHW-1] && (shv[SHW-2:SAMPLE_BITS-1] != '1);

  always_comb begin
    if (sat_hi) begin
      y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (sat_lo) begin
      y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y = $signed(shv[SAMPLE_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered  <= y;
      saturated <= sat_hi || sat_lo;
    end
  end

endmodule

### design/fir_filter_valid_mode.sv
// valid-mode fir correlation, q1.15 samples and coefficients
//
// din carries one sample item (sample, block_start) per valid/ready handshake;
// dout carries one result item (filtered, saturated). block_start restarts the
// window count. once tap_count samples of the current block have arrived, each
// further sample yields one result: the oldest window sample meets c[0], the
// newest meets c[tap_count-1]. tap_count 0, or a window not yet full, yields none.
// configuration goes through cfg_we / cfg_index / cfg_data while no item is in
// flight: index 0 tap_count, 1 coef_index, 2 coef_value (stored at coef_index).
// timing: an item that yields no result is taken in the idle state, which stays
// ready; an item that yields a result is accepted, walks the taps on the single
// shared multiply-accumulate, then drains the ram read / product / accumulate
// stages, and its result shows on dout in the cycle after it is loaded.
// the result sits in an output register, so the next sample is accepted while
// it waits; if dout stalls, the following result holds in the accumulator and
// din is not ready until the output register frees up.
// reset marks every coefficient unwritten (read as zero) and clears tap_count,
// coef_index, the window count and the history pointer; no clearing pass is needed
module fir_filter_valid_mode
  import fvm_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  fvm_in_if.sink                    din,
  fvm_out_if.source                 dout,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  fvm_cmd_t    cmd;
  fvm_status_t st;

  // sequencer: idle -> run over the taps -> drain the mac pipe
  fvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .status   (st),
    .cmd      (cmd)
  );

  // history and coefficient rams, shared mac, rounding and output register
  fvm_dpath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (st),
    .sample      (din.sample),
    .block_start (din.block_start),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (dout.ready),
    .out_valid   (dout.valid),
    .filtered    (dout.filtered),
    .saturated   (dout.saturated)
  );

  // no new item while products are still in flight
  assert property (@(posedge clk) disable iff (rst) st.pipe_busy |-> !din.ready)
    else $error("input ready while mac pipe busy");

  // a result is loaded only into a free output register
  assert property (@(posedge clk) disable iff (rst) cmd.load_out |-> st.out_free)
    else $error("result loaded over a pending result");

  // an item that completes a window starts the tap walk with no wait state between
  assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && st.produce) |=> cmd.issue)
    else $error("tap walk did not start after accept");

  // a loaded result shows on the output channel next cycle
  assert property (@(posedge clk) disable iff (rst) cmd.load_out |=> dout.valid)
    else $error("loaded result not presented");

endmodule
